>>> rtl/fibonacci_counter_unit_macros.svh
// Assertion helpers for the counter unit; expect clk and arst_n in scope.
`ifndef FIBONACCI_COUNTER_UNIT_MACROS_SVH
`define FIBONACCI_COUNTER_UNIT_MACROS_SVH

// same-cycle implication
`define FCU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fibc_pkg.sv
package fibc_pkg;

	localparam int FIBC_WIDTH = 32;
	localparam int UPC_W = 5;

	typedef enum logic [2:0] {
		CMD_UP   = 3'd0,
		CMD_DOWN = 3'd1,
		CMD_NTH  = 3'd2,
		CMD_GE   = 3'd3,
		CMD_LE   = 3'd4,
		CMD_GT   = 3'd5,
		CMD_LT   = 3'd6,
		CMD_CLR  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		UOP_CLR,
		UOP_UP,
		UOP_DOWN,
		UOP_RET
	} uop_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_V_GT_CUR,
		CND_CUR_GT_V,
		CND_CUR_LE_V,
		CND_CUR_GE_V,
		CND_CNT_LT_V
	} cond_t;

	typedef struct packed {
		cond_t             cond;
		uop_t              op;
		logic [UPC_W-1:0]  target;
	} uword_t;

	typedef struct packed {
		logic v_gt_cur;
		logic cur_gt_v;
		logic cnt_lt_v;
		logic would_sat;
	} dp_status_t;

	typedef struct packed {
		logic start;
		logic exec;
		uop_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] operand;
	} in_word_t;

	typedef struct packed {
		logic [31:0] term;
		logic [31:0] term_before;
		logic        overflow;
	} out_word_t;

endpackage

>>> rtl/fibc_urom.sv
module fibc_urom (
	input  logic [fibc_pkg::UPC_W-1:0] pc,
	input  logic [2:0]                 command,
	output fibc_pkg::uword_t           word,
	output logic [fibc_pkg::UPC_W-1:0] entry
);
	import fibc_pkg::*;

	localparam logic [UPC_W-1:0] A_RET      = UPC_W'(0);
	localparam logic [UPC_W-1:0] A_UP       = UPC_W'(1);
	localparam logic [UPC_W-1:0] A_DOWN     = UPC_W'(2);
	localparam logic [UPC_W-1:0] A_CLR      = UPC_W'(3);
	localparam logic [UPC_W-1:0] A_NTH      = UPC_W'(4);
	localparam logic [UPC_W-1:0] A_NTH_LOOP = UPC_W'(5);
	localparam logic [UPC_W-1:0] A_NTH_RET  = UPC_W'(6);
	localparam logic [UPC_W-1:0] A_GE       = UPC_W'(7);
	localparam logic [UPC_W-1:0] A_GE_LOOP  = UPC_W'(8);
	localparam logic [UPC_W-1:0] A_GE_RET   = UPC_W'(9);
	localparam logic [UPC_W-1:0] A_LE       = UPC_W'(10);
	localparam logic [UPC_W-1:0] A_LE_LOOP  = UPC_W'(11);
	localparam logic [UPC_W-1:0] A_LE_FIX   = UPC_W'(12);
	localparam logic [UPC_W-1:0] A_LE_RET   = UPC_W'(13);
	localparam logic [UPC_W-1:0] A_GT       = UPC_W'(14);
	localparam logic [UPC_W-1:0] A_GT_LOOP  = UPC_W'(15);
	localparam logic [UPC_W-1:0] A_GT_FIX   = UPC_W'(16);
	localparam logic [UPC_W-1:0] A_GT_ABOVE = UPC_W'(17);
	localparam logic [UPC_W-1:0] A_GT_RET   = UPC_W'(18);
	localparam logic [UPC_W-1:0] A_LT       = UPC_W'(19);
	localparam logic [UPC_W-1:0] A_LT_LOOP  = UPC_W'(20);
	localparam logic [UPC_W-1:0] A_LT_FIX   = UPC_W'(21);
	localparam logic [UPC_W-1:0] A_LT_RET   = UPC_W'(22);

	function automatic uword_t uw(cond_t c, uop_t o, logic [UPC_W-1:0] t);
		uword_t w;
		w.cond = c;
		w.op = o;
		w.target = t;
		return w;
	endfunction

	always_comb begin
		unique case (pc)
			A_RET:      word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
			A_UP:       word = uw(CND_ALWAYS,   UOP_UP,   A_RET);
			A_DOWN:     word = uw(CND_ALWAYS,   UOP_DOWN, A_RET);
			A_CLR:      word = uw(CND_ALWAYS,   UOP_CLR,  A_RET);
			A_NTH:      word = uw(CND_ALWAYS,   UOP_CLR,  A_NTH_LOOP);
			A_NTH_LOOP: word = uw(CND_CNT_LT_V, UOP_UP,   A_NTH_LOOP);
			A_NTH_RET:  word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
			A_GE:       word = uw(CND_ALWAYS,   UOP_CLR,  A_GE_LOOP);
			A_GE_LOOP:  word = uw(CND_V_GT_CUR, UOP_UP,   A_GE_LOOP);
			A_GE_RET:   word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
			A_LE:       word = uw(CND_ALWAYS,   UOP_CLR,  A_LE_LOOP);
			A_LE_LOOP:  word = uw(CND_V_GT_CUR, UOP_UP,   A_LE_LOOP);
			A_LE_FIX:   word = uw(CND_CUR_GT_V, UOP_DOWN, A_LE_RET);
			A_LE_RET:   word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
			A_GT:       word = uw(CND_ALWAYS,   UOP_CLR,  A_GT_LOOP);
			A_GT_LOOP:  word = uw(CND_V_GT_CUR, UOP_UP,   A_GT_LOOP);
			A_GT_FIX:   word = uw(CND_CUR_GT_V, UOP_DOWN, A_GT_ABOVE);
			A_GT_ABOVE: word = uw(CND_CUR_LE_V, UOP_UP,   A_GT_ABOVE);
			A_GT_RET:   word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
			A_LT:       word = uw(CND_ALWAYS,   UOP_CLR,  A_LT_LOOP);
			A_LT_LOOP:  word = uw(CND_V_GT_CUR, UOP_UP,   A_LT_LOOP);
			A_LT_FIX:   word = uw(CND_CUR_GE_V, UOP_DOWN, A_LT_RET);
			A_LT_RET:   word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
			default:    word = uw(CND_ALWAYS,   UOP_RET,  A_RET);
		endcase
	end

	always_comb begin
		unique case (cmd_t'(command))
			CMD_UP:   entry = A_UP;
			CMD_DOWN: entry = A_DOWN;
			CMD_NTH:  entry = A_NTH;
			CMD_GE:   entry = A_GE;
			CMD_LE:   entry = A_LE;
			CMD_GT:   entry = A_GT;
			CMD_LT:   entry = A_LT;
			CMD_CLR:  entry = A_CLR;
			default:  entry = A_CLR;
		endcase
	end

endmodule

>>> rtl/fibc_useq.sv
`include "fibonacci_counter_unit_macros.svh"

module fibc_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [2:0]           command,
	input  fibc_pkg::dp_status_t st,
	input  logic                 out_free,
	output logic                 busy,
	output logic                 emit,
	output fibc_pkg::dp_ctrl_t   ctrl
);
	import fibc_pkg::*;

	logic             busy_q;
	logic [UPC_W-1:0] pc_q;
	logic [UPC_W-1:0] pc_next;
	logic [UPC_W-1:0] entry;
	uword_t           word;
	logic             cond_true;

	fibc_urom u_urom (
		.pc      (pc_q),
		.command (command),
		.word    (word),
		.entry   (entry)
	);

	always_comb begin
		unique case (word.cond)
			CND_ALWAYS:   cond_true = 1'b1;
			CND_V_GT_CUR: cond_true = st.v_gt_cur;
			CND_CUR_GT_V: cond_true = st.cur_gt_v;
			CND_CUR_LE_V: cond_true = !st.cur_gt_v;
			CND_CUR_GE_V: cond_true = !st.v_gt_cur;
			CND_CNT_LT_V: cond_true = st.cnt_lt_v;
			default:      cond_true = 1'b0;
		endcase
	end

	// leave a step-up loop on saturation
	always_comb begin
		pc_next = pc_q + UPC_W'(1);
		if (cond_true && !(word.op == UOP_UP && st.would_sat && word.cond != CND_ALWAYS)) begin
			pc_next = word.target;
		end
	end

	assign busy = busy_q;
	assign emit = busy_q && word.op == UOP_RET && out_free;
	assign ctrl.start = go;
	assign ctrl.exec = busy_q && word.op != UOP_RET && cond_true;
	assign ctrl.op = word.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			pc_q <= entry;
		end else if (busy_q) begin
			if (emit) begin
				busy_q <= 1'b0;
			end else if (word.op != UOP_RET) begin
				pc_q <= pc_next;
			end
		end
	end

	`FCU_ASSERT_IMPL(a_go_when_idle, go, !busy_q, "command taken while sequencer busy")
	`FCU_ASSERT_IMPL(a_exec_xor_emit, ctrl.exec || emit, busy_q && !(ctrl.exec && emit), "datapath op and result in same step")
	`FCU_ASSERT_NEXT(a_emit_idles, emit && !go, !busy_q, "sequencer stays busy after result")

endmodule

>>> rtl/fibc_dpath.sv
`include "fibonacci_counter_unit_macros.svh"

module fibc_dpath #(
	parameter int WIDTH = fibc_pkg::FIBC_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fibc_pkg::dp_ctrl_t   ctrl,
	input  logic [31:0]          operand,
	output fibc_pkg::dp_status_t st,
	output fibc_pkg::out_word_t  res
);
	import fibc_pkg::*;

	localparam int CntW = $clog2(2 * WIDTH + 4);
	localparam int OpW = (WIDTH < 32) ? WIDTH : 32;

	logic [WIDTH-1:0] cur_q;
	logic [WIDTH-1:0] prev_q;
	logic [WIDTH-1:0] v_q;
	logic [WIDTH-1:0] before_q;
	logic [CntW-1:0]  cnt_q;
	logic             ovf_q;
	logic             would_sat;

	assign would_sat = (cur_q != '0) && (prev_q > ~cur_q);

	assign st.v_gt_cur = v_q > cur_q;
	assign st.cur_gt_v = cur_q > v_q;
	assign st.cnt_lt_v = WIDTH'(cnt_q) < v_q;
	assign st.would_sat = would_sat;

	assign res.term = 32'(cur_q[OpW-1:0]);
	assign res.term_before = 32'(before_q[OpW-1:0]);
	assign res.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			prev_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.start) begin
			ovf_q <= 1'b0;
		end else if (ctrl.exec) begin
			unique case (ctrl.op)
				UOP_CLR: begin
					cur_q <= '0;
					prev_q <= '0;
				end
				UOP_UP: begin
					if (cur_q == '0) begin
						cur_q <= WIDTH'(1);
					end else if (would_sat) begin
						ovf_q <= 1'b1;
					end else begin
						prev_q <= cur_q;
						cur_q <= cur_q + prev_q;
					end
				end
				UOP_DOWN: begin
					if (prev_q == '0) begin
						cur_q <= '0;
					end else begin
						cur_q <= prev_q;
						prev_q <= cur_q - prev_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			v_q <= WIDTH'(operand[OpW-1:0]);
			before_q <= cur_q;
		end
		if (ctrl.exec && ctrl.op == UOP_CLR) begin
			cnt_q <= '0;
		end else if (ctrl.exec && ctrl.op == UOP_UP) begin
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	`FCU_ASSERT_IMPL(a_prev_le_cur, 1'b1, prev_q <= cur_q, "previous term above current term")
	`FCU_ASSERT_NEXT(a_up_grows, ctrl.exec && ctrl.op == UOP_UP && !ctrl.start && prev_q != '0 && !would_sat, cur_q > $past(cur_q), "step up did not grow the term")
	`FCU_ASSERT_IMPL(a_ovf_cause, $rose(ovf_q), $past(ctrl.exec && ctrl.op == UOP_UP && would_sat), "overflow without saturating step")

endmodule

>>> rtl/fibonacci_counter_unit.sv
// Fibonacci counter unit.
// Input channel (in_valid/in_ready/in_data) takes one command word: step up,
// step down, clear, nth term, or a search for the term nearest an operand.
// Output channel (out_valid/out_ready/out_data) returns one word per command:
// the new term, the term held before the command, and an overflow flag.
// A microcode sequencer runs each command as a short program; one microword
// executes per cycle, except while a finished result waits for the output
// register, and a step-up loop adds one term per cycle. Up, down and clear
// run one datapath microword and return; nth and searches clear the terms,
// step up in a loop and, for LE, GT and LT, adjust the term; then return.
// The step-up loop sets the rate: one command in flight at a time, so
// in_ready is low from accept until its result enters the output register.
// The output register lets the next command be accepted while a result waits.
// If the receiver stalls, a finished result holds in its final microword
// until the output register frees up.
// Reset clears both terms to zero, the overflow flag and the handshakes.
module fibonacci_counter_unit #(
	parameter int WIDTH = fibc_pkg::FIBC_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fibc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fibc_pkg::out_word_t out_data
);
	import fibc_pkg::*;

	logic       busy;
	logic       emit;
	logic       go;
	logic       out_free;
	logic       out_valid_q;
	out_word_t  out_data_q;
	out_word_t  res;
	dp_ctrl_t   ctrl;
	dp_status_t st;

	assign in_ready = !busy;
	assign go = in_valid && !busy;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	fibc_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.command  (in_data.command),
		.st       (st),
		.out_free (out_free),
		.busy     (busy),
		.emit     (emit),
		.ctrl     (ctrl)
	);

	fibc_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.operand (in_data.operand),
		.st      (st),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res;
		end
	end

endmodule
